// File: rtl/core/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants, status types and the symbol table lookup for the
// integer to radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itrd_pkg;

  // default number of symbols the table may hold
  localparam int MAX_SYMBOLS_DEF = 16;

  // field widths
  localparam int NUM_W      = 32;
  localparam int SYM_W      = 8;
  localparam int DIG_W      = 4;
  localparam int BLEN_W     = 5;
  localparam int MAX_DIGITS = 32;
  localparam int CNT_W      = 6;
  localparam int TBL_ENTRIES = 2 ** DIG_W;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 64;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_SYM_LO   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SYM_HI   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_BASE_LEN = 2'd2;

  // special characters
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

  // symbol table validator status
  typedef struct packed {
    logic done;
    logic ok;
  } chk_stat_t;

  // digit divider status
  typedef struct packed {
    logic             done;
    logic [DIG_W-1:0] digit;
    logic [NUM_W-1:0] quot;
  } div_stat_t;

  // symbol byte for a digit value out of the two table words
  function automatic logic [SYM_W-1:0] sym_at(input logic [CFG_DW-1:0] lo,
                                              input logic [CFG_DW-1:0] hi,
                                              input logic [DIG_W-1:0]  idx);
    logic [2*CFG_DW-1:0] tbl;
    tbl = {hi, lo};
    return tbl[{idx, 3'b000} +: SYM_W];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/itrd_if.sv
// ----------------------------------------------------------------------------
// itrd_if
// Valid/ready channels of the converter: number in, characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface itrd_in_if import itrd_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface itrd_out_if import itrd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] out_char;
  logic             last;
  logic             bad_base;

  modport source (output valid, output out_char, output last, output bad_base,
                  input ready);
  modport sink   (input valid, input out_char, input last, input bad_base,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/int_to_radix_digits.sv
// ----------------------------------------------------------------------------
// int_to_radix_digits
// Converts a signed 32-bit number into its digit symbols in a configured
// radix, most significant first, with a leading '-' for negative numbers.
// ----------------------------------------------------------------------------
// Sequence: after acceptance the symbol table is checked, then each digit
//   takes one run of the divider (16 divider steps and a hand-off).
// Throughput: one number at a time, its pace set by the two-bit-per-cycle
//   divider; characters leave one per cycle while the output is not stalled.
// Reset: synchronous, active low; the symbol table and base_len clear to 0,
//   so every number gives a bad base result until the table is written.
`default_nettype none

module int_to_radix_digits import itrd_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  itrd_in_if.sink                in_ch,
  itrd_out_if.source             out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_BAD   = 3'd4;

  localparam int STACK_W = MAX_DIGITS * DIG_W;

  // configuration registers
  logic [CFG_DW-1:0] sym_lo_r;
  logic [CFG_DW-1:0] sym_hi_r;
  logic [BLEN_W-1:0] base_len_r;

  // control and data path
  logic [2:0]         state_r;
  logic [NUM_W-1:0]   mag_r;
  logic               neg_r;
  logic [STACK_W-1:0] stack_r;
  logic [CNT_W-1:0]   cnt_r;

  // output word register
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_char_r;
  logic               out_last_r;
  logic               out_bad_r;

  logic               accept;
  logic               len_bad;
  logic               out_free;
  logic               more;
  logic               chk_go;
  logic               div_go;
  logic [NUM_W-1:0]   div_dividend;
  logic [NUM_W-1:0]   in_raw;
  chk_stat_t          chk_stat;
  div_stat_t          div_stat;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_lo_r   <= '0;
      sym_hi_r   <= '0;
      base_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SYM_LO:   sym_lo_r   <= cfg_wdata;
        REG_SYM_HI:   sym_hi_r   <= cfg_wdata;
        REG_BASE_LEN: base_len_r <= cfg_wdata[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and sequencing terms
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_raw       = in_ch.number;
  assign len_bad      = (base_len_r < BLEN_W'(2)) || (base_len_r > BLEN_W'(MAX_SYMBOLS));
  assign out_free     = !out_valid_r || out_ch.ready;
  assign more         = (div_stat.quot != '0) && (cnt_r < CNT_W'(MAX_DIGITS - 1));
  assign chk_go       = accept && !len_bad;
  assign div_go       = ((state_r == S_CHECK) && chk_stat.done && chk_stat.ok) ||
                        ((state_r == S_DIV) && div_stat.done && more);
  assign div_dividend = (state_r == S_CHECK) ? mag_r : div_stat.quot;

  itrd_symchk #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_symchk (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (chk_go),
    .base_len (base_len_r),
    .sym_lo   (sym_lo_r),
    .sym_hi   (sym_hi_r),
    .stat     (chk_stat)
  );

  itrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .radix    (base_len_r),
    .stat     (div_stat)
  );

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            neg_r   <= in_raw[NUM_W-1];
            cnt_r   <= '0;
            state_r <= len_bad ? S_BAD : S_CHECK;
          end
        end
        S_CHECK: begin
          if (chk_stat.done) begin
            state_r <= chk_stat.ok ? S_DIV : S_BAD;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            cnt_r <= cnt_r + CNT_W'(1);
            if (!more) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (neg_r) begin
              neg_r <= 1'b0;
            end else begin
              cnt_r <= cnt_r - CNT_W'(1);
              if (cnt_r == CNT_W'(1)) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        S_BAD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // magnitude, digit stack and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r <= in_raw[NUM_W-1] ? (NUM_W'(0) - in_raw) : in_raw;
    end
    if ((state_r == S_DIV) && div_stat.done) begin
      stack_r <= {stack_r[STACK_W-DIG_W-1:0], div_stat.digit};
    end else if ((state_r == S_EMIT) && out_free && !neg_r) begin
      stack_r <= {DIG_W'(0), stack_r[STACK_W-1:DIG_W]};
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_bad_r <= 1'b0;
      if (neg_r) begin
        out_char_r <= CH_MINUS;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= sym_at(sym_lo_r, sym_hi_r, stack_r[DIG_W-1:0]);
        out_last_r <= (cnt_r == CNT_W'(1));
      end
    end else if ((state_r == S_BAD) && out_free) begin
      out_char_r <= CH_NUL;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.bad_base = out_bad_r;

endmodule

`default_nettype wire

// File: rtl/core/itrd_symchk.sv
// ----------------------------------------------------------------------------
// itrd_symchk
// Serial symbol table validator: one symbol per cycle is checked against
// the reserved bytes and against every later symbol in use.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_symchk import itrd_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [BLEN_W-1:0] base_len,
  input  wire logic [CFG_DW-1:0] sym_lo,
  input  wire logic [CFG_DW-1:0] sym_hi,
  output chk_stat_t              stat
);

  localparam int IW = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;

  logic          busy_r;
  logic          done_r;
  logic          ok_r;
  logic          bad_r;
  logic [IW-1:0] idx_r;

  logic [DIG_W-1:0] cur_idx;
  logic [SYM_W-1:0] cur_sym;
  logic             hit;
  logic             dup;
  logic             last_sym;

  // reserved bytes and duplicates among the later symbols in use
  always_comb begin
    cur_idx  = DIG_W'(idx_r);
    cur_sym  = sym_at(sym_lo, sym_hi, cur_idx);
    hit      = (cur_sym == CH_NUL) || (cur_sym == CH_PLUS) || (cur_sym == CH_MINUS);
    dup      = 1'b0;
    for (int j = 0; j < TBL_ENTRIES; j++) begin
      if ((j > int'(idx_r)) && (j < int'(base_len)) &&
          (sym_at(sym_lo, sym_hi, DIG_W'(j)) == cur_sym)) begin
        dup = 1'b1;
      end
    end
    last_sym = (BLEN_W'(idx_r) == (base_len - BLEN_W'(1)));
  end

  // walk the symbols in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ok_r   <= 1'b0;
      bad_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        bad_r  <= 1'b0;
        idx_r  <= '0;
      end else if (busy_r) begin
        bad_r <= bad_r | hit | dup;
        if (last_sym) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          ok_r   <= !(bad_r | hit | dup);
        end else begin
          idx_r <= idx_r + IW'(1);
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.ok   = ok_r;

endmodule

`default_nettype wire

// File: rtl/core/itrd_div.sv
// ----------------------------------------------------------------------------
// itrd_div
// Digit-serial divider: divides a 32-bit magnitude by the radix, two
// dividend bits per cycle, giving the low digit and the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_div import itrd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [NUM_W-1:0]  dividend,
  input  wire logic [BLEN_W-1:0] radix,
  output div_stat_t              stat
);

  localparam int STEPS = NUM_W / 2;
  localparam int SW    = $clog2(STEPS);
  localparam int VW    = DIG_W + 2;

  logic             busy_r;
  logic             done_r;
  logic [SW-1:0]    step_r;
  logic [DIG_W-1:0] rem_r;
  logic [NUM_W-1:0] quot_r;

  logic [VW-1:0]    part;
  logic [VW-1:0]    r1;
  logic [VW-1:0]    r2;
  logic [VW-1:0]    r3;
  logic [1:0]       qd;
  logic [VW-1:0]    sub;
  logic [VW-1:0]    diff;

  // one radix-4 step of the long division
  always_comb begin
    part = {rem_r, quot_r[NUM_W-1 -: 2]};
    r1   = VW'(radix);
    r2   = {radix, 1'b0};
    r3   = r2 + r1;
    if (part >= r3) begin
      qd  = 2'd3;
      sub = r3;
    end else if (part >= r2) begin
      qd  = 2'd2;
      sub = r2;
    end else if (part >= r1) begin
      qd  = 2'd1;
      sub = r1;
    end else begin
      qd  = 2'd0;
      sub = '0;
    end
    diff = part - sub;
  end

  // step sequencer and quotient shift register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + SW'(1);
        if (step_r == SW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r  <= '0;
      quot_r <= dividend;
    end else if (busy_r) begin
      rem_r  <= diff[DIG_W-1:0];
      quot_r <= {quot_r[NUM_W-3:0], qd};
    end
  end

  assign stat.done  = done_r;
  assign stat.digit = rem_r;
  assign stat.quot  = quot_r;

endmodule

`default_nettype wire

// File: rtl/core/itrd_sva.sv
// ----------------------------------------------------------------------------
// itrd_sva
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_sva (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       out_last,
  input wire logic       out_bad
);

  // a bad base word is a lone, empty, final word
  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad |-> out_last && (out_char == 8'h00))
    else $error("bad base word not final or not empty");

  // a good word always carries a nonzero character
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad |-> (out_char != 8'h00))
    else $error("zero character in a good run");

  // one number at a time: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a number is in progress");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
                                $stable(out_last) && $stable(out_bad))
    else $error("stalled output word changed");

endmodule

bind int_to_radix_digits itrd_sva u_itrd_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .out_last  (out_ch.last),
  .out_bad   (out_ch.bad_base)
);

`default_nettype wire
